@@ hdl/fbha_pkg.sv @@
// ----------------------------------------------------------------------------
// fbha_pkg
// Shared types and codes for the free block heap allocator.
// ----------------------------------------------------------------------------
package fbha_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic CFG_MIN_BLOCK = 1'b0;
    localparam logic CFG_HEADER    = 1'b1;

    localparam logic [15:0] MIN_BLOCK_RESET = 16'd256;
    localparam logic [7:0]  HEADER_RESET    = 8'd16;

    typedef struct packed {
        logic        func;
        logic [31:0] byte_count;
        logic [31:0] user_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted_addr;
        logic [31:0] granted_size;
        logic [6:0]  free_count;
    } rsp_t;

    typedef struct packed {
        logic [31:0] size;
        logic [31:0] hdr;
    } slot_t;

endpackage

@@ hdl/free_block_heap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// free_block_heap_allocator_core
// Heap-ordered free list allocator with first-fit scan and split.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the start transfer until the result
// strobe. A sequencer drives one slot store with one read and one write per
// cycle. An allocate scans the slots in order, then refills the taken slot
// and sifts it up and down, then puts the remainder with a sift up when it
// exceeds the header size. A free is a sift up only. The result is shown for
// one cycle on done and cannot be held off. No clearing pass.
// ----------------------------------------------------------------------------
module free_block_heap_allocator_core #(
    parameter int FREE_SLOTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fbha_pkg::req_t      req,
    output logic                done,
    output fbha_pkg::rsp_t      rsp,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int CW = $clog2(FREE_SLOTS + 1);

    typedef enum logic [17:0] {
        S_IDLE    = 18'b000000000000000001,
        S_SCAN_RD = 18'b000000000000000010,
        S_SCAN_CK = 18'b000000000000000100,
        S_TAKE_RD = 18'b000000000000001000,
        S_TAKE_WR = 18'b000000000000010000,
        S_UP_RD   = 18'b000000000000100000,
        S_UP_WT   = 18'b000000000001000000,
        S_UP_CK   = 18'b000000000010000000,
        S_DN_RDL  = 18'b000000000100000000,
        S_DN_RDR  = 18'b000000001000000000,
        S_DN_WT   = 18'b000000010000000000,
        S_DN_CK   = 18'b000000100000000000,
        S_SWAP2   = 18'b000001000000000000,
        S_PUT     = 18'b000010000000000000,
        S_DONE    = 18'b000100000000000000,
        S_UP_RDS  = 18'b001000000000000000,
        S_DN_RDS  = 18'b010000000000000000,
        S_DN_WT2  = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] min_reg;
    logic [7:0]  hdr_reg;
    logic [CW-1:0] cnt_reg;

    // sequencing and payload registers
    logic [31:0]     want_reg;
    logic [CW-1:0]   idx_reg;      // scan index / sift node (wide for bound)
    logic [AW-1:0]   par_reg;      // other end of a compare/swap
    fbha_pkg::slot_t cur_reg;      // node being sifted
    fbha_pkg::slot_t oth_reg;      // parent or chosen child
    fbha_pkg::slot_t lft_reg;
    fbha_pkg::slot_t got_reg;      // block taken by allocate
    logic            pend_put_reg; // remainder still to insert
    logic            dn_after_reg; // sift down follows sift up
    logic [1:0]      st_reg;
    logic [31:0]     gaddr_reg, gsize_reg;
    logic [AW-1:0]   swap_a_reg;
    fbha_pkg::slot_t swap_d_reg;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    fbha_pkg::slot_t wdata, rdata;

    fbha_slot_ram #(.DEPTH(FREE_SLOTS), .AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= fbha_pkg::MIN_BLOCK_RESET;
            hdr_reg <= fbha_pkg::HEADER_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fbha_pkg::CFG_MIN_BLOCK)
                min_reg <= cfg_data;
            else
                hdr_reg <= cfg_data[7:0];
        end
    end

    // single shared comparator
    logic [31:0] cmp_a, cmp_b;
    logic        cmp_lt;
    assign cmp_lt = cmp_a < cmp_b;

    // child and parent indices (wide to test against count)
    logic [CW:0] lidx, ridx, pidx;
    assign lidx = {idx_reg, 1'b0} + (CW+1)'(1);
    assign ridx = {idx_reg, 1'b0} + (CW+1)'(2);
    assign pidx = ({1'b0, idx_reg} - (CW+1)'(1)) >> 1;

    logic [31:0] diff;
    assign diff = got_reg.size - want_reg;

    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = cur_reg;
        raddr = idx_reg[AW-1:0];
        cmp_a = 32'd0;
        cmp_b = 32'd0;
        case (state_reg)
            S_IDLE:
            begin
                cmp_a = req.byte_count;
                cmp_b = {16'd0, min_reg};
            end
            S_SCAN_CK:
            begin
                cmp_a = rdata.size;
                cmp_b = want_reg;
            end
            S_UP_CK:
            begin
                cmp_a = cur_reg.size;
                cmp_b = oth_reg.size;
            end
            S_DN_CK:
            begin
                // left < right picks the left child
                cmp_a = lft_reg.size;
                cmp_b = rdata.size;
            end
            S_DN_WT2:
            begin
                cmp_a = oth_reg.size;
                cmp_b = cur_reg.size;
            end
            S_PUT:
            begin
                cmp_a = {24'd0, hdr_reg};
                cmp_b = diff;
            end
            default:
            begin
                cmp_a = 32'd0;
                cmp_b = 32'd0;
            end
        endcase
        case (state_reg)
            S_SCAN_RD, S_TAKE_RD: raddr = idx_reg[AW-1:0];
            S_UP_RD:  raddr = pidx[AW-1:0];
            S_DN_RDL: raddr = lidx[AW-1:0];
            S_DN_RDR, S_DN_WT: raddr = ridx[AW-1:0];
            S_TAKE_WR:
            begin
                // count already reduced: it indexes the last entry
                raddr = AW'(cnt_reg);
            end
            S_SWAP2:
            begin
                we = 1'b1;
                waddr = swap_a_reg;
                wdata = swap_d_reg;
            end
            default: raddr = idx_reg[AW-1:0];
        endcase
        if (state_reg == S_UP_CK && cmp_lt)
        begin
            we = 1'b1;
            waddr = idx_reg[AW-1:0];
            wdata = oth_reg;
        end
        if (state_reg == S_DN_CK || state_reg == S_DN_WT2)
        begin
            we = 1'b0;
        end
        if (state_reg == S_UP_RDS)
        begin
            we = 1'b1;
            waddr = idx_reg[AW-1:0];
            wdata = cur_reg;
        end
        if (state_reg == S_DN_RDS)
        begin
            we = 1'b1;
            waddr = idx_reg[AW-1:0];
            wdata = oth_reg;
        end
    end

    // Sift node value lives in cur_reg; memory at idx holds stale data until
    // the sift ends, when cur_reg is written home (S_UP_RDS / swaps).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            done <= 1'b0;
            pend_put_reg <= 1'b0;
            dn_after_reg <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        want_reg <= cmp_lt ? {16'd0, min_reg} : req.byte_count;
                        idx_reg <= '0;
                        gaddr_reg <= '0;
                        gsize_reg <= '0;
                        st_reg <= fbha_pkg::ST_OK;
                        pend_put_reg <= 1'b0;
                        dn_after_reg <= 1'b0;
                        if (req.func == fbha_pkg::FUNC_ALLOC)
                        begin
                            if (req.byte_count == 32'd0)
                            begin
                                st_reg <= fbha_pkg::ST_ZERO;
                                state_reg <= S_DONE;
                            end
                            else if (cnt_reg == '0)
                            begin
                                st_reg <= fbha_pkg::ST_NO_FIT;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_SCAN_RD;
                        end
                        else if (req.user_addr == 32'd0)
                            state_reg <= S_DONE;
                        else if (req.byte_count == 32'd0)
                        begin
                            st_reg <= fbha_pkg::ST_ZERO;
                            state_reg <= S_DONE;
                        end
                        else if (cnt_reg == CW'(FREE_SLOTS))
                        begin
                            st_reg <= fbha_pkg::ST_FULL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            cur_reg.size <= req.byte_count;
                            cur_reg.hdr <= req.user_addr - {24'd0, hdr_reg};
                            idx_reg <= cnt_reg;
                            cnt_reg <= cnt_reg + CW'(1);
                            state_reg <= S_UP_RD;
                        end
                    end
                end
                S_SCAN_RD: state_reg <= S_SCAN_CK;
                S_SCAN_CK:
                begin
                    if (!cmp_lt)
                    begin
                        got_reg <= rdata;
                        cnt_reg <= cnt_reg - CW'(1);
                        state_reg <= S_TAKE_WR;
                    end
                    else if (idx_reg + CW'(1) >= cnt_reg)
                    begin
                        st_reg <= fbha_pkg::ST_NO_FIT;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_TAKE_WR: state_reg <= S_TAKE_RD;
                S_TAKE_RD:
                begin
                    // rdata holds the last entry (cnt already reduced)
                    gaddr_reg <= got_reg.hdr + {24'd0, hdr_reg};
                    pend_put_reg <= 1'b1;
                    if (idx_reg < cnt_reg)
                    begin
                        cur_reg <= rdata;
                        dn_after_reg <= 1'b1;
                        state_reg <= S_UP_RD;
                    end
                    else
                        state_reg <= S_PUT;
                end
                S_UP_RD:
                begin
                    if (idx_reg == '0)
                        state_reg <= S_UP_RDS;
                    else
                        state_reg <= S_UP_WT;
                end
                S_UP_WT:
                begin
                    oth_reg <= rdata;
                    state_reg <= S_UP_CK;
                end
                S_UP_CK:
                begin
                    if (cmp_lt)
                    begin
                        // parent moved down into idx, climb
                        idx_reg <= CW'(pidx);
                        state_reg <= S_UP_RD;
                    end
                    else
                        state_reg <= S_UP_RDS;
                end
                S_UP_RDS:
                begin
                    if (dn_after_reg)
                    begin
                        dn_after_reg <= 1'b0;
                        state_reg <= S_DN_RDL;
                    end
                    else
                        state_reg <= pend_put_reg ? S_PUT : S_DONE;
                end
                S_DN_RDL:
                begin
                    if (lidx >= (CW+1)'(cnt_reg))
                        state_reg <= pend_put_reg ? S_PUT : S_DONE;
                    else
                        state_reg <= S_DN_RDR;
                end
                S_DN_RDR:
                begin
                    lft_reg <= rdata;
                    state_reg <= S_DN_WT;
                end
                S_DN_WT:
                begin
                    state_reg <= S_DN_CK;
                end
                S_DN_CK:
                begin
                    // choose child: left if left < right (right absent = max)
                    if (ridx >= (CW+1)'(cnt_reg) || cmp_lt)
                    begin
                        oth_reg <= lft_reg;
                        par_reg <= lidx[AW-1:0];
                    end
                    else
                    begin
                        oth_reg <= rdata;
                        par_reg <= ridx[AW-1:0];
                    end
                    state_reg <= S_DN_WT2;
                end
                S_DN_WT2:
                begin
                    if (cmp_lt)
                    begin
                        // child smaller: child up to idx, node down
                        state_reg <= S_DN_RDS;
                    end
                    else
                        state_reg <= pend_put_reg ? S_PUT : S_DONE;
                end
                S_DN_RDS:
                begin
                    swap_a_reg <= par_reg;
                    swap_d_reg <= cur_reg;
                    idx_reg <= CW'(par_reg);
                    state_reg <= S_SWAP2;
                end
                S_SWAP2: state_reg <= S_DN_RDL;
                S_PUT:
                begin
                    pend_put_reg <= 1'b0;
                    if (cmp_lt)
                    begin
                        gsize_reg <= want_reg;
                        if (cnt_reg != CW'(FREE_SLOTS))
                        begin
                            cur_reg.size <= diff - {24'd0, hdr_reg};
                            cur_reg.hdr <= got_reg.hdr + {24'd0, hdr_reg}
                                           + want_reg;
                            idx_reg <= cnt_reg;
                            cnt_reg <= cnt_reg + CW'(1);
                            state_reg <= S_UP_RD;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                    else
                    begin
                        gsize_reg <= got_reg.size;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE)
        begin
            rsp.status <= st_reg;
            rsp.granted_addr <= (st_reg == fbha_pkg::ST_OK) ? gaddr_reg : 32'd0;
            rsp.granted_size <= (st_reg == fbha_pkg::ST_OK) ? gsize_reg : 32'd0;
            rsp.free_count <= 7'(cnt_reg);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(FREE_SLOTS))
        else $error("entry count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start not taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_DONE)
        else $error("stray strobe");

endmodule

@@ hdl/fbha_slot_ram.sv @@
// ----------------------------------------------------------------------------
// fbha_slot_ram
// Simple dual port slot store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fbha_slot_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  fbha_pkg::slot_t wdata,
    input  logic [AW-1:0]   raddr,
    output fbha_pkg::slot_t rdata
);

    fbha_pkg::slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
